[rtl/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication through reset");

`endif

[rtl/ncgpm_pkg.sv]
// types and constants of the nat64 customer group port mapper
// used by every module of the block but the checker; depends on nothing
package ncgpm_pkg;

  localparam int unsigned IDX_W = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PREFIX6_UPPER         = 3'd0;
  localparam logic [IDX_W-1:0] REG_PREFIX6_LOWER         = 3'd1;
  localparam logic [IDX_W-1:0] REG_PREFIX6_LENGTH        = 3'd2;
  localparam logic [IDX_W-1:0] REG_GROUP_BOUNDARY_LENGTH = 3'd3;
  localparam logic [IDX_W-1:0] REG_IPV4_PREFIX_LENGTH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PORT_RANGE_BITS       = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIVISION_LENGTH       = 3'd6;

  localparam logic [7:0] MAX_V6_LEN  = 8'd128;
  localparam logic [5:0] MAX_V4_LEN  = 6'd32;
  localparam logic [5:0] MIN_DIV_LEN = 6'd17;
  localparam logic [4:0] MAX_GROUP_W = 5'd16;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] port_offset;
    logic [15:0] range_hop;
  } item_t;

  typedef struct packed {
    logic        in_customer;
    logic [15:0] group_number;
    logic [31:0] first_port;
  } result_t;

  // configuration after range clamping
  typedef struct packed {
    logic [63:0] prefix_upper;
    logic [63:0] prefix_lower;
    logic [7:0]  prefix_len;    // 0..128
    logic [7:0]  boundary_len;  // 0..128
    logic [5:0]  ipv4_len;      // 0..32
    logic [3:0]  range_bits;    // 1..15
    logic [5:0]  div_len;       // 17..32
  } cfg_t;

endpackage

[rtl/ncgpm_cfg.sv]
// configuration register file of the port mapper, clamped on write
// depends on ncgpm_pkg
module ncgpm_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [ncgpm_pkg::IDX_W-1:0] wr_index,
  input  logic [63:0]                wr_data,
  output ncgpm_pkg::cfg_t            cfg
);

  logic [7:0] len8;
  logic [5:0] len6;
  logic [3:0] bits4;

  assign len8  = wr_data[7:0];
  assign len6  = wr_data[5:0];
  assign bits4 = wr_data[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prefix_upper <= '0;
      cfg.prefix_lower <= '0;
      cfg.prefix_len   <= '0;
      cfg.boundary_len <= '0;
      cfg.ipv4_len     <= ncgpm_pkg::MAX_V4_LEN;
      cfg.range_bits   <= 4'd1;
      cfg.div_len      <= ncgpm_pkg::MAX_V4_LEN;
    end else if (wr_en) begin
      case (wr_index)
        ncgpm_pkg::REG_PREFIX6_UPPER: begin
          cfg.prefix_upper <= wr_data;
        end
        ncgpm_pkg::REG_PREFIX6_LOWER: begin
          cfg.prefix_lower <= wr_data;
        end
        ncgpm_pkg::REG_PREFIX6_LENGTH: begin
          cfg.prefix_len <= (len8 > ncgpm_pkg::MAX_V6_LEN) ? ncgpm_pkg::MAX_V6_LEN : len8;
        end
        ncgpm_pkg::REG_GROUP_BOUNDARY_LENGTH: begin
          cfg.boundary_len <= (len8 > ncgpm_pkg::MAX_V6_LEN) ? ncgpm_pkg::MAX_V6_LEN : len8;
        end
        ncgpm_pkg::REG_IPV4_PREFIX_LENGTH: begin
          cfg.ipv4_len <= (len6 > ncgpm_pkg::MAX_V4_LEN) ? ncgpm_pkg::MAX_V4_LEN : len6;
        end
        ncgpm_pkg::REG_PORT_RANGE_BITS: begin
          cfg.range_bits <= (bits4 == 4'd0) ? 4'd1 : bits4;
        end
        ncgpm_pkg::REG_DIVISION_LENGTH: begin
          if (len6 < ncgpm_pkg::MIN_DIV_LEN) begin
            cfg.div_len <= ncgpm_pkg::MIN_DIV_LEN;
          end else if (len6 > ncgpm_pkg::MAX_V4_LEN) begin
            cfg.div_len <= ncgpm_pkg::MAX_V4_LEN;
          end else begin
            cfg.div_len <= len6;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ncgpm_group.sv]
// prefix match and group field extraction from the ipv6 source address
// depends on ncgpm_pkg
module ncgpm_group (
  input  logic [63:0]     addr_high,
  input  logic [63:0]     addr_low,
  input  ncgpm_pkg::cfg_t cfg,
  output logic            in_customer,
  output logic [15:0]     group,
  output logic [15:0]     group_mask
);

  logic [127:0] addr;
  logic [127:0] prefix;
  logic [127:0] match_mask;
  logic [127:0] shifted;
  logic [7:0]   span;
  logic [4:0]   width;
  logic [16:0]  mask_wide;

  assign addr   = {addr_high, addr_low};
  assign prefix = {cfg.prefix_upper, cfg.prefix_lower};

  always_comb begin
    if (cfg.prefix_len == 8'd0) begin
      match_mask = '0;
    end else begin
      match_mask = {128{1'b1}} << (ncgpm_pkg::MAX_V6_LEN - cfg.prefix_len);
    end
  end

  assign in_customer = (((addr ^ prefix) & match_mask) == '0);

  // group width, zero unless the boundary sits after the prefix end, at most 16
  assign span = (cfg.boundary_len > cfg.prefix_len) ? (cfg.boundary_len - cfg.prefix_len) : 8'd0;
  assign width = (span > {3'd0, ncgpm_pkg::MAX_GROUP_W}) ? ncgpm_pkg::MAX_GROUP_W : span[4:0];

  assign mask_wide  = (17'd1 << width) - 17'd1;
  assign group_mask = mask_wide[15:0];

  // bring the bit just above the boundary down to bit 0
  assign shifted = addr >> (ncgpm_pkg::MAX_V6_LEN - cfg.boundary_len);
  assign group   = shifted[15:0] & group_mask;

endmodule

[rtl/ncgpm_port.sv]
// first port of the group's interleaved block at or below the offset
// or its first block if under range_hop; depends on ncgpm_pkg
module ncgpm_port (
  input  logic [31:0]     port_offset,
  input  logic [15:0]     range_hop,
  input  logic [15:0]     group,
  input  logic [15:0]     group_mask,
  input  ncgpm_pkg::cfg_t cfg,
  output logic [31:0]     first_port
);

  logic [6:0]  space_exp;
  logic [31:0] space_mask;
  logic [31:0] offset_red;
  logic [5:0]  shift_wide;
  logic [3:0]  shift;
  logic [31:0] block_base;
  logic [31:0] block_idx;
  logic [15:0] own_block;
  logic [15:0] back_blocks;
  logic [31:0] back;

  // total port space is 2^(32 - ipv4_len + range_bits)
  assign space_exp  = 7'd32 - {1'b0, cfg.ipv4_len} + {3'd0, cfg.range_bits};
  assign space_mask = (space_exp >= 7'd32) ? {32{1'b1}} : ~({32{1'b1}} << space_exp[4:0]);
  assign offset_red = port_offset & space_mask;

  assign shift_wide = ncgpm_pkg::MAX_V4_LEN - cfg.div_len;
  assign shift      = shift_wide[3:0];

  assign block_idx  = offset_red >> shift;
  assign block_base = block_idx << shift;
  assign own_block  = block_idx[15:0] & group_mask;
  // step back to the group's block, wrapping within the group count
  assign back_blocks = (own_block - group) & group_mask;
  assign back        = {16'd0, back_blocks} << shift;

  always_comb begin
    if (offset_red < {16'd0, range_hop}) begin
      first_port = {16'd0, group} << shift;
    end else begin
      first_port = block_base - back;
    end
  end

endmodule

[rtl/nat64_customer_group_port_mapper.sv]
// nat64 customer group port mapper: top level with input and result registers
// depends on ncgpm_pkg, ncgpm_cfg, ncgpm_group, ncgpm_port
//
// usage:
//   input channel: a word (item) is taken at a rising edge where start is high
//   and busy is low; busy stays low, so a word can be given every cycle.
//   result channel: done is high for exactly one cycle with the result word;
//   the receiver takes it at that edge and cannot hold it off.
//   config port: wr_en, wr_index and wr_data write one register per edge;
//   the user must write only while no word is in flight; it is not enforced.
// path: a word is held in the input register, then goes through the match,
//   group and port logic into the result register, where done marks it.
// throughput: one word per cycle; the path between the two registers is a
//   128-bit mask compare, a 128-bit shift and a 32-bit subtract.
// reset: rst (synchronous) empties both registers, so no done follows, and
//   loads the configuration reset values.
module nat64_customer_group_port_mapper (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ncgpm_pkg::item_t           item,
  output logic                       done,
  output ncgpm_pkg::result_t         result,
  input  logic                       wr_en,
  input  logic [ncgpm_pkg::IDX_W-1:0] wr_index,
  input  logic [63:0]                wr_data
);

  ncgpm_pkg::cfg_t    cfg;
  ncgpm_pkg::item_t   in_item;
  ncgpm_pkg::result_t result_next;
  logic               in_valid;
  logic               accept;
  logic [15:0]        group;
  logic [15:0]        group_mask;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ncgpm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  ncgpm_group u_group (
    .addr_high   (in_item.addr_high),
    .addr_low    (in_item.addr_low),
    .cfg         (cfg),
    .in_customer (result_next.in_customer),
    .group       (group),
    .group_mask  (group_mask)
  );

  assign result_next.group_number = group;

  ncgpm_port u_port (
    .port_offset (in_item.port_offset),
    .range_hop   (in_item.range_hop),
    .group       (group),
    .group_mask  (group_mask),
    .cfg         (cfg),
    .first_port  (result_next.first_port)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= accept;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= item;
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

endmodule

[rtl/ncgpm_checker.sv]
// port-level checker for the port mapper and its bind to the top level
// depends on assert_macros.svh and nat64_customer_group_port_mapper
`include "assert_macros.svh"

module ncgpm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  logic accept;

  assign accept = start && !busy;

  // every accepted word comes out as a done after the input register
  `ASSERT_NEXT(a_word_out, clk, rst, accept, ##1 done)
  // no result word without a word taken before it
  `ASSERT_IMPLIES(a_no_phantom, clk, rst, done, $past(accept, 2))
  // reset flushes the pipeline
  `ASSERT_NEXT_ALWAYS(a_reset_flush, clk, rst, !done)
  // the block never pushes back on the sender
  `ASSERT_IMPLIES(a_never_busy, clk, rst, 1'b1, !busy)

endmodule

bind nat64_customer_group_port_mapper ncgpm_checker u_ncgpm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
